// File: rtl/core/qcpf_pkg.sv
`default_nettype none

package qcpf_pkg;

    localparam logic [7:0] WARMUP_PACKETS = 8'd100;
    localparam int unsigned PKT_BYTES     = 16;
    localparam int unsigned BODY_BYTES    = PKT_BYTES - 1;

    // configuration register indexes
    localparam logic [1:0] REG_SUBTYPE     = 2'd0;
    localparam logic [1:0] REG_PLUS_ID     = 2'd1;
    localparam logic [1:0] REG_VTX_CHANNEL = 2'd2;

    // subtype codes
    localparam logic [1:0] SUBTYPE_FIRST  = 2'd0;
    localparam logic [1:0] SUBTYPE_SECOND = 2'd1;
    localparam logic [1:0] SUBTYPE_THIRD  = 2'd2;

    localparam logic [6:0] VTX_CHANNEL_RESET = 7'd64;

    // header and filler bytes
    localparam logic [7:0] HDR_STICKS    = 8'h20;
    localparam logic [7:0] HDR_VTX       = 8'h40;
    localparam logic [7:0] VTX_TRAILER   = 8'h82;
    localparam logic [7:0] HDR_SPECIAL_A = 8'hE8;
    localparam logic [7:0] HDR_SPECIAL_B = 8'hE9;
    localparam logic [7:0] STICK_NEUTRAL = 8'h80;
    localparam logic [7:0] PLUS_FILL     = 8'h64;
    localparam logic [7:0] FLIGHT_MODE   = 8'h42;
    localparam logic [7:0] SPECIAL_A_AT  = 8'd10;
    localparam logic [7:0] SPECIAL_B_AT  = 8'd20;

    typedef struct packed {
        logic [7:0] throttle;
        logic [7:0] rudder;
        logic [7:0] elevator;
        logic [7:0] aileron;
        logic [8:0] switches;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] packet_byte;
        logic [3:0] byte_index;
        logic       last_byte;
    } t_out_beat;

    typedef logic [BODY_BYTES-1:0][7:0] t_body;

endpackage

`default_nettype wire

// File: rtl/core/quad_control_packet_framer.sv
`default_nettype none

// channel   dir  beat                     handshake
// in        in   sticks + switches        i_in_valid / o_in_stall
// out       out  one packet byte          o_out_valid / i_out_stall
// cfg       in   register write           i_cfg_we, i_cfg_index, i_cfg_wdata
//
// one input beat yields sixteen output beats, one per cycle while the output is not
// stalled; the output serialiser sets that rate
// an accepted beat is framed combinationally into a registered holding slot,
// which moves to the serialiser register when that is idle or its last byte
// leaves. the checksum byte is accumulated while bytes 0 to 14 go out
// reset is synchronous, active low; stalls on the output simply hold the byte

module quad_control_packet_framer (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  qcpf_pkg::t_in_beat   i_in_data,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output qcpf_pkg::t_out_beat  o_out_data,
    input  wire                  i_out_stall,
    input  wire                  i_cfg_we,
    input  wire  [1:0]           i_cfg_index,
    input  wire  [6:0]           i_cfg_wdata
);

    logic [1:0] r_subtype;
    logic       r_plus_id;
    logic [6:0] r_vtx_channel;

    logic [7:0] r_warmup, n_warmup;
    logic [7:0] r_sent_ch, n_sent_ch;
    logic [7:0] r_special, n_special;

    logic                r_hold_valid, n_hold_valid;
    qcpf_pkg::t_body     r_hold_pkt;
    qcpf_pkg::t_body     n_pkt;

    logic                r_out_valid, n_out_valid;
    qcpf_pkg::t_body     r_out_pkt, n_out_pkt;
    logic [3:0]          r_idx, n_idx;
    logic [7:0]          r_sum, n_sum;

    logic in_fire, out_fire, out_done, load;

    // framing terms
    logic        freq;
    logic [7:0]  wc1;
    logic        warm;
    logic [14:0] ch_mul;
    logic [3:0]  ch_div;
    logic [3:0]  ch_rem;
    logic [7:0]  special_inc;
    logic        is_a, is_b, is_third;
    logic [8:0]  sw;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_subtype     <= qcpf_pkg::SUBTYPE_FIRST;
            r_plus_id     <= 1'b0;
            r_vtx_channel <= qcpf_pkg::VTX_CHANNEL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                qcpf_pkg::REG_SUBTYPE:     r_subtype     <= i_cfg_wdata[1:0];
                qcpf_pkg::REG_PLUS_ID:     r_plus_id     <= i_cfg_wdata[0];
                qcpf_pkg::REG_VTX_CHANNEL: r_vtx_channel <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // packet assembly
    always_comb begin
        sw       = i_in_data.switches;
        freq     = (r_sent_ch != {1'b0, r_vtx_channel}) ||
                   (r_warmup == qcpf_pkg::WARMUP_PACKETS);
        wc1      = r_warmup + {7'd0, freq};
        warm     = wc1 < qcpf_pkg::WARMUP_PACKETS;
        // divide by ten via reciprocal, exact for seven-bit values
        ch_mul   = 15'(r_vtx_channel) * 15'd205;
        ch_div   = ch_mul[14:11];
        ch_rem   = 4'(r_vtx_channel - 7'(ch_div) * 7'd10);
        is_a     = !r_plus_id && (r_subtype == qcpf_pkg::SUBTYPE_FIRST);
        is_b     = !is_a && (r_subtype == qcpf_pkg::SUBTYPE_SECOND);
        is_third = !is_a && !is_b && (r_subtype == qcpf_pkg::SUBTYPE_THIRD);
        special_inc = r_special + 8'd1;

        n_warmup  = wc1 + {7'd0, warm};
        n_sent_ch = freq ? {1'b0, r_vtx_channel} : r_sent_ch;
        n_special = r_special;

        n_pkt = '0;
        if (freq) begin
            n_pkt[0] = qcpf_pkg::HDR_VTX;
            n_pkt[1] = {4'd0, ch_div} + 8'd50;
            n_pkt[2] = {4'd0, ch_rem} + 8'd10;
            n_pkt[3] = qcpf_pkg::VTX_TRAILER;
        end else begin
            n_pkt[0] = qcpf_pkg::HDR_STICKS;
            n_pkt[2] = i_in_data.throttle;
        end
        n_pkt[4] = i_in_data.rudder;
        n_pkt[6] = ~i_in_data.elevator;
        n_pkt[8] = ~i_in_data.aileron;

        if (is_a) begin
            n_pkt[9]  = warm ? 8'h0E : {4'b0000, sw[3], sw[0], 1'b1, sw[1]};
            n_pkt[10] = 8'h64;
            n_pkt[11] = 8'hDB;
            n_pkt[12] = 8'h04;
            n_pkt[13] = 8'h26;
            n_pkt[14] = 8'h79;
        end else if (is_b) begin
            n_pkt[9]  = warm ? 8'h02 : {1'b0, sw[5], 1'b0, sw[0], 2'b00, sw[6], sw[1]};
            n_pkt[10] = 8'h18;
            n_pkt[12] = 8'h5C;
            n_pkt[14] = 8'hF6;
        end else begin
            n_pkt[3] = is_third ? 8'h00 : qcpf_pkg::PLUS_FILL;
            n_pkt[5] = n_pkt[3];
            n_pkt[7] = n_pkt[3];
            if (is_third) begin
                n_pkt[9]  = {sw[7], sw[4], sw[5], 1'b0, sw[3], sw[0], 1'b1, sw[1]};
                n_pkt[11] = qcpf_pkg::FLIGHT_MODE;
                n_pkt[13] = {4'd0, sw[8], 1'b0, sw[4], sw[2]};
            end else begin
                n_pkt[9]  = {4'b0000, sw[4], 1'b1, 1'b1, sw[1]};
                n_pkt[10] = 8'h19;
                n_pkt[12] = 8'h5C;
                n_pkt[13] = {sw[3], 6'd0, sw[2]};
                n_pkt[14] = 8'h49;
            end
            if (warm) begin
                n_pkt[2]  = qcpf_pkg::STICK_NEUTRAL;
                n_pkt[4]  = qcpf_pkg::STICK_NEUTRAL;
                n_pkt[6]  = qcpf_pkg::STICK_NEUTRAL;
                n_pkt[8]  = qcpf_pkg::STICK_NEUTRAL;
                n_pkt[9]  = 8'h06;
                n_pkt[13] = 8'h00;
            end
            if (is_third) begin
                // every tenth and twentieth third-layout packet is a special frame
                if (special_inc == qcpf_pkg::SPECIAL_A_AT) begin
                    n_pkt    = '0;
                    n_pkt[0] = qcpf_pkg::HDR_SPECIAL_A;
                end else if (special_inc == qcpf_pkg::SPECIAL_B_AT) begin
                    n_pkt    = '0;
                    n_pkt[0] = qcpf_pkg::HDR_SPECIAL_B;
                end
                n_special = (special_inc >= qcpf_pkg::SPECIAL_B_AT) ? 8'd0 : special_inc;
            end
        end
    end

    // handshake and serialiser
    assign in_fire  = i_in_valid && !r_hold_valid;
    assign out_fire = r_out_valid && !i_out_stall;
    assign out_done = out_fire && (r_idx == 4'd15);
    assign load     = r_hold_valid && (!r_out_valid || out_done);

    always_comb begin
        n_hold_valid = in_fire || (r_hold_valid && !load);
        n_out_valid  = r_out_valid;
        n_out_pkt    = r_out_pkt;
        n_idx        = r_idx;
        n_sum        = r_sum;
        if (load) begin
            n_out_valid = 1'b1;
            n_out_pkt   = r_hold_pkt;
            n_idx       = 4'd0;
            n_sum       = 8'd0;
        end else if (out_fire) begin
            n_out_pkt   = {8'd0, r_out_pkt[qcpf_pkg::BODY_BYTES-1:1]};
            n_idx       = r_idx + 4'd1;
            n_sum       = r_sum + r_out_pkt[0];
            n_out_valid = !out_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warmup     <= 8'd0;
            r_sent_ch    <= 8'd0;
            r_special    <= 8'd0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_idx        <= 4'd0;
            r_sum        <= 8'd0;
        end else begin
            if (in_fire) begin
                r_warmup  <= n_warmup;
                r_sent_ch <= n_sent_ch;
                r_special <= n_special;
            end
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
            r_idx        <= n_idx;
            r_sum        <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_hold_pkt <= n_pkt;
        end
        r_out_pkt <= n_out_pkt;
    end

    assign o_in_stall             = r_hold_valid;
    assign o_out_valid            = r_out_valid;
    assign o_out_data.byte_index  = r_idx;
    assign o_out_data.last_byte   = (r_idx == 4'd15);
    assign o_out_data.packet_byte = (r_idx == 4'd15) ? 8'(8'd0 - r_sum) : r_out_pkt[0];

    // checks
    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire && (r_idx != 4'd15) |=> r_out_valid && (r_idx == $past(r_idx) + 4'd1))
        else $error("byte index skipped");

    a_hold_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_valid && !r_out_valid |=> r_out_valid && (r_idx == 4'd0))
        else $error("held packet not moved to serialiser");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_done && !r_hold_valid |=> !r_out_valid)
        else $error("serialiser kept running after last byte");

    a_special_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_special < qcpf_pkg::SPECIAL_B_AT)
        else $error("special frame count out of range");

endmodule

`default_nettype wire
